/* rtl/staggered_grid_rk2_trace_assert.svh */
// Assertion helpers used by the datapath (sgrt_dpath).
`ifndef STAGGERED_GRID_RK2_TRACE_ASSERT_SVH
`define STAGGERED_GRID_RK2_TRACE_ASSERT_SVH

// Same-cycle implication.
`define SGRT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SGRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/sgrt_pkg.sv */
package sgrt_pkg;

    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned POS_W   = 24;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned DT_W    = 20;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned MID_W   = 39;
    localparam int unsigned PROD_W  = 53;
    localparam int unsigned IN_W    = 120;
    localparam int unsigned USER_W  = 4;
    localparam int unsigned OUT_W   = 104;

    localparam logic [DT_W-1:0] DT_RESET = 20'd13107;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_INTERP = 2'd1;
    localparam logic [1:0] OP_TRACE  = 2'd2;

    localparam logic [1:0] COMP_U    = 2'd0;
    localparam logic [1:0] COMP_V    = 2'd1;
    localparam logic [1:0] COMP_W    = 2'd2;
    localparam logic [1:0] COMP_NONE = 2'd3;

    localparam logic [3:0] READ_END   = 4'd8;
    localparam logic [3:0] LERP_LAST  = 4'd6;
    localparam logic [3:0] TRACE_LAST = 4'd5;

    typedef struct packed {
        logic       clr;
        logic       load_in;
        logic       wr;
        logic       setup;
        logic       rd;
        logic       cap;
        logic       lerp;
        logic       store;
        logic       trace;
        logic       out_load;
        logic [1:0] ax;
        logic       pass;
        logic [3:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] comp;
        logic       clr_last;
        logic       out_busy;
    } t_sts;

endpackage

/* rtl/sgrt_ram.sv */
module sgrt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4913
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sgrt_ctrl.sv */
module sgrt_ctrl
    import sgrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECODE = 9'b000000100,
        S_SETUP  = 9'b000001000,
        S_READ   = 9'b000010000,
        S_LERP   = 9'b000100000,
        S_MID    = 9'b001000000,
        S_FIN    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_ax, n_ax;
    logic       r_pass, n_pass;
    logic [3:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_ax       = r_ax;
        n_pass     = r_pass;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.ax   = r_ax;
        o_cmd.pass = r_pass;
        o_cmd.cnt  = r_cnt;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_pass = 1'b0;
                n_cnt  = '0;
                priority if (i_sts.op == OP_WRITE) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_DONE;
                end else if (i_sts.op == OP_INTERP && i_sts.comp != COMP_NONE) begin
                    n_ax    = i_sts.comp;
                    n_state = S_SETUP;
                end else if (i_sts.op == OP_TRACE) begin
                    n_ax    = COMP_U;
                    n_state = S_SETUP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_cnt       = '0;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd  = (r_cnt != READ_END);
                o_cmd.cap = (r_cnt != '0);
                if (r_cnt == READ_END) begin
                    n_cnt   = '0;
                    n_state = S_LERP;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_LERP: begin
                o_cmd.lerp = 1'b1;
                if (r_cnt == LERP_LAST) begin
                    o_cmd.store = 1'b1;
                    n_cnt       = '0;
                    priority if (i_sts.op != OP_TRACE) begin
                        n_state = S_DONE;
                    end else if (r_ax != COMP_W) begin
                        n_ax    = r_ax + 2'd1;
                        n_state = S_SETUP;
                    end else if (!r_pass) begin
                        n_state = S_MID;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_MID: begin
                o_cmd.trace = 1'b1;
                if (r_cnt == TRACE_LAST) begin
                    n_cnt   = '0;
                    n_pass  = 1'b1;
                    n_ax    = COMP_U;
                    n_state = S_SETUP;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_FIN: begin
                o_cmd.trace = 1'b1;
                if (r_cnt == TRACE_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ax    <= '0;
            r_pass  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ax    <= n_ax;
            r_pass  <= n_pass;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* rtl/sgrt_dpath.sv */
`include "staggered_grid_rk2_trace_assert.svh"

module sgrt_dpath
    import sgrt_pkg::*;
#(
    parameter int GRID_CELLS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  logic [USER_W-1:0] i_s_tuser,
    input  logic              i_cfg_we,
    input  logic [DT_W-1:0]   i_cfg_wdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata
);

    localparam int SIDE  = GRID_CELLS + 1;
    localparam int DEPTH = SIDE * SIDE * SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SIDE);
    localparam int QW    = $clog2(GRID_CELLS) + FRAC_W;
    localparam logic signed [MID_W-1:0] FACE_HI = MID_W'(GRID_CELLS * 65536 - 1);
    localparam logic signed [MID_W-1:0] SIDE_LO = MID_W'(32768);
    localparam logic signed [MID_W-1:0] SIDE_HI = MID_W'(GRID_CELLS * 65536 - 32769);
    localparam logic signed [MID_W-1:0] POS_HI  = MID_W'(8388607);
    localparam logic signed [MID_W-1:0] POS_LO  = -MID_W'(8388608);

    logic [1:0]               r_op, r_comp;
    logic                     r_fwd;
    logic [IDX_W-1:0]         r_ci, r_cj, r_ck;
    logic [VAL_W-1:0]         r_wval;
    logic signed [POS_W-1:0]  r_p   [3];
    logic signed [MID_W-1:0]  r_mid [3];
    logic signed [VAL_W-1:0]  r_vel [3];
    logic [CW-1:0]            r_cell [3];
    logic [FRAC_W-1:0]        r_fr  [3];
    logic signed [VAL_W-1:0]  r_q   [8];
    logic signed [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]         r_sample;
    logic [POS_W-1:0]         r_nx  [3];
    logic [OUT_W-1:0]         r_out;
    logic                     r_out_valid;
    logic [AW-1:0]            r_clr;
    logic [DT_W-1:0]          r_dt;

    function automatic logic [QW-1:0] clamp_q(input logic signed [MID_W-1:0] v,
                                               input logic face);
        logic signed [MID_W-1:0] lo, hi, c;
        lo = face ? '0 : SIDE_LO;
        hi = face ? FACE_HI : SIDE_HI;
        if (v < lo) begin
            c = lo;
        end else if (v > hi) begin
            c = hi;
        end else begin
            c = v;
        end
        if (!face) begin
            c = c - SIDE_LO;
        end
        return c[QW-1:0];
    endfunction

    // lookup setup
    logic [QW-1:0] s_q [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s_q[a] = clamp_q(i_cmd.pass ? r_mid[a]
                                        : {{(MID_W-POS_W){r_p[a][POS_W-1]}}, r_p[a]},
                             i_cmd.ax == 2'(a));
        end
    end

    // read and write addressing
    logic [2:0]    corner;
    logic [CW-1:0] ri, rj, rk, wi, wj, wk;
    logic [AW-1:0] raddr, waddr, ra1, wa1;
    logic          wr_ok;
    assign corner = i_cmd.cnt[2:0];
    assign ri     = r_cell[0] + CW'(corner[0]);
    assign rj     = r_cell[1] + CW'(corner[1]);
    assign rk     = r_cell[2] + CW'(corner[2]);
    assign ra1    = AW'(ri) * AW'(SIDE) + AW'(rj);
    assign raddr  = ra1 * AW'(SIDE) + AW'(rk);
    assign wi     = CW'(r_ci);
    assign wj     = CW'(r_cj);
    assign wk     = CW'(r_ck);
    assign wa1    = AW'(wi) * AW'(SIDE) + AW'(wj);
    assign waddr  = i_cmd.clr ? r_clr : wa1 * AW'(SIDE) + AW'(wk);
    assign wr_ok  = i_cmd.wr && int'(r_ci) <= GRID_CELLS && int'(r_cj) <= GRID_CELLS
                    && int'(r_ck) <= GRID_CELLS;

    logic [VAL_W-1:0] ram_q [3];
    logic [VAL_W-1:0] wdata;
    assign wdata = i_cmd.clr ? '0 : r_wval;

    for (genvar g = 0; g < 3; g++) begin : g_grid
        sgrt_ram #(
            .WIDTH (VAL_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.clr || (wr_ok && r_comp == 2'(g))),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (i_cmd.rd),
            .i_raddr (raddr),
            .o_rdata (ram_q[g])
        );
    end

    logic signed [VAL_W-1:0] rd_sel;
    always_comb begin
        unique case (i_cmd.ax)
            COMP_U:  rd_sel = ram_q[0];
            COMP_V:  rd_sel = ram_q[1];
            default: rd_sel = ram_q[2];
        endcase
    end

    // blend: a + floor((b - a) * f / 2^16)
    logic [FRAC_W-1:0]       lf;
    logic signed [VAL_W:0]   ldiff;
    logic signed [49:0]      lprod;
    logic signed [VAL_W-1:0] lres;
    always_comb begin
        if (i_cmd.cnt < 4'd4) begin
            lf = r_fr[0];
        end else if (i_cmd.cnt < LERP_LAST) begin
            lf = r_fr[1];
        end else begin
            lf = r_fr[2];
        end
        ldiff = {r_q[1][VAL_W-1], r_q[1]} - {r_q[0][VAL_W-1], r_q[0]};
        lprod = ldiff * $signed({1'b0, lf});
        lres  = r_q[0] + lprod[47:16];
    end

    // trace step
    logic [1:0]              taxis;
    logic signed [PROD_W-1:0] trsum;
    logic signed [MID_W-1:0] td, tp, tsum;
    always_comb begin
        taxis = i_cmd.cnt[2:1];
        trsum = r_prod + (i_cmd.pass ? PROD_W'(32768) : PROD_W'(65536));
        td    = i_cmd.pass ? MID_W'(trsum >>> 16) : MID_W'(trsum >>> 17);
        tp    = {{(MID_W-POS_W){r_p[taxis][POS_W-1]}}, r_p[taxis]};
        tsum  = r_fwd ? tp + td : tp - td;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_s_tuser[1:0];
            r_comp   <= i_s_tuser[3:2];
            r_ci     <= i_s_tdata[4:0];
            r_cj     <= i_s_tdata[9:5];
            r_ck     <= i_s_tdata[14:10];
            r_wval   <= i_s_tdata[46:15];
            r_p[0]   <= i_s_tdata[70:47];
            r_p[1]   <= i_s_tdata[94:71];
            r_p[2]   <= i_s_tdata[118:95];
            r_fwd    <= i_s_tdata[119];
            r_sample <= '0;
            for (int a = 0; a < 3; a++) begin
                r_nx[a] <= '0;
            end
        end
        if (i_cmd.setup) begin
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= CW'(s_q[a][QW-1:FRAC_W]);
                r_fr[a]   <= s_q[a][FRAC_W-1:0];
            end
        end
        if (i_cmd.cap) begin
            for (int i = 0; i < 7; i++) begin
                r_q[i] <= r_q[i+1];
            end
            r_q[7] <= rd_sel;
        end
        if (i_cmd.lerp) begin
            for (int i = 0; i < 6; i++) begin
                r_q[i] <= (int'(i_cmd.cnt) + i == 6) ? lres : r_q[i+2];
            end
            if (i_cmd.cnt == '0) begin
                r_q[6] <= lres;
            end
        end
        if (i_cmd.store) begin
            if (r_op == OP_TRACE) begin
                r_vel[i_cmd.ax] <= lres;
            end else begin
                r_sample <= lres;
            end
        end
        if (i_cmd.trace) begin
            if (!i_cmd.cnt[0]) begin
                r_prod <= $signed({1'b0, r_dt}) * r_vel[taxis];
            end else if (!i_cmd.pass) begin
                r_mid[taxis] <= tsum;
            end else if (tsum > POS_HI) begin
                r_nx[taxis] <= POS_HI[POS_W-1:0];
            end else if (tsum < POS_LO) begin
                r_nx[taxis] <= POS_LO[POS_W-1:0];
            end else begin
                r_nx[taxis] <= tsum[POS_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out <= {r_nx[2], r_nx[1], r_nx[0], r_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr       <= '0;
            r_dt        <= DT_RESET;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we) begin
                r_dt <= i_cfg_wdata;
            end
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.comp     = r_comp;
    assign o_sts.clr_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out;

    `SGRT_ASSERT_IMPL(a_no_overwrite, i_cmd.out_load, !r_out_valid || i_m_tready)
    `SGRT_ASSERT_IMPL(a_clear_alone, i_cmd.clr, !i_cmd.rd && !i_cmd.wr && !i_cmd.load_in)
    `SGRT_ASSERT_IMPL(a_store_last, i_cmd.store, i_cmd.lerp && i_cmd.cnt == LERP_LAST)
    `SGRT_ASSERT_NEXT(a_out_set, i_cmd.out_load, r_out_valid)

endmodule

/* rtl/staggered_grid_rk2_trace.sv */
// Operations: write, interpolate, RK2 trace. One item is in work at a time; the next
// is taken in the cycle after the result loads, later if the output stalls.
// Each of the six trace lookups runs a clamp, eight reads from the one read port
// of a grid RAM plus the registered read, and seven blends.
// Reset: synchronous, active low; a clearing pass over all (GRID_CELLS+1)^3 grid
// points (4913 at 16 cells) zeroes the grids before the first item is taken.
module staggered_grid_rk2_trace
    import sgrt_pkg::*;
#(
    parameter int GRID_CELLS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // cell_i, cell_j, cell_k, write_value, pos_x, pos_y, pos_z, trace_forward
    input  logic [IN_W-1:0]   i_s_tdata,
    // operation, component
    input  logic [USER_W-1:0] i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // sample_value, new_x, new_y, new_z
    output logic [OUT_W-1:0]  o_m_tdata,
    input  logic              i_cfg_we,
    input  logic [DT_W-1:0]   i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    sgrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sgrt_dpath #(
        .GRID_CELLS (GRID_CELLS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgrt_pkg::*;

    localparam int NCELL = 16;
    localparam int SIDE = NCELL + 1;
    localparam int DEPTH = SIDE * SIDE * SIDE;
    localparam int WATCH_LIMIT = 40000;
    localparam longint P_MAX = 8388607;
    localparam longint P_MIN = -8388608;

    typedef struct packed {
        logic [23:0] new_z;
        logic [23:0] new_y;
        logic [23:0] new_x;
        logic [31:0] sample_value;
    } t_trace_out;

    class grid_scoreboard;
        int signed ug[DEPTH];
        int signed vg[DEPTH];
        int signed wg[DEPTH];
        logic [DT_W-1:0] dt;
        t_trace_out pending[$];
        int errors;

        function new();
            foreach (ug[n]) begin
                ug[n] = 0;
                vg[n] = 0;
                wg[n] = 0;
            end
            dt = DT_RESET;
            errors = 0;
        endfunction

        function longint rnd_shift(longint v, int s);
            longint r;
            r = v + (longint'(1) <<< (s - 1));
            return r >>> s;
        endfunction

        function longint lerp(longint a, longint b, longint f);
            return rnd_shift(a * (65536 - f) + b * f - 32768, 16);
        endfunction

        function longint rd(logic [1:0] c, longint i, longint j, longint k);
            int n;
            n = int'((i * SIDE + j) * SIDE + k);
            if (c == COMP_U) return ug[n];
            if (c == COMP_V) return vg[n];
            return wg[n];
        endfunction

        function longint lookup(logic [1:0] c, longint p[3]);
            longint cl[3];
            longint fr[3];
            longint q;
            longint x00, x01, x10, x11, y0, y1;
            if (c == COMP_NONE) return 0;
            for (int a = 0; a < 3; a++) begin
                if (a == c) begin
                    q = p[a] < 0 ? 0 : (p[a] > NCELL * 65536 - 1 ? NCELL * 65536 - 1 : p[a]);
                end else begin
                    q = p[a] < 32768 ? 32768 :
                        (p[a] > NCELL * 65536 - 32769 ? NCELL * 65536 - 32769 : p[a]);
                    q = q - 32768;
                end
                cl[a] = q >>> 16;
                fr[a] = q & 65535;
            end
            x00 = lerp(rd(c, cl[0], cl[1], cl[2]), rd(c, cl[0] + 1, cl[1], cl[2]), fr[0]);
            x01 = lerp(rd(c, cl[0], cl[1], cl[2] + 1),
                       rd(c, cl[0] + 1, cl[1], cl[2] + 1), fr[0]);
            x10 = lerp(rd(c, cl[0], cl[1] + 1, cl[2]),
                       rd(c, cl[0] + 1, cl[1] + 1, cl[2]), fr[0]);
            x11 = lerp(rd(c, cl[0], cl[1] + 1, cl[2] + 1),
                       rd(c, cl[0] + 1, cl[1] + 1, cl[2] + 1), fr[0]);
            y0 = lerp(x00, x10, fr[1]);
            y1 = lerp(x01, x11, fr[1]);
            return lerp(y0, y1, fr[2]);
        endfunction

        function void note_input(logic [3:0] user, logic [IN_W-1:0] d);
            t_trace_out r;
            logic [1:0] op, c;
            longint p[3], m[3], vel[3], dd, nv;
            int n;
            op = user[1:0];
            c = user[3:2];
            r = '0;
            if (op == OP_WRITE) begin
                if (c != COMP_NONE && d[4:0] <= NCELL && d[9:5] <= NCELL
                        && d[14:10] <= NCELL) begin
                    n = (int'(d[4:0]) * SIDE + int'(d[9:5])) * SIDE + int'(d[14:10]);
                    if (c == COMP_U) ug[n] = d[46:15];
                    else if (c == COMP_V) vg[n] = d[46:15];
                    else wg[n] = d[46:15];
                end
            end
            // position fields start after cell indexes and write value
            p[0] = longint'($signed(d[70:47]));
            p[1] = longint'($signed(d[94:71]));
            p[2] = longint'($signed(d[118:95]));
            if (op == OP_INTERP) begin
                r.sample_value = 32'(lookup(c, p));
            end else if (op == OP_TRACE) begin
                for (int a = 0; a < 3; a++) vel[a] = lookup(a[1:0], p);
                for (int a = 0; a < 3; a++) begin
                    dd = rnd_shift(longint'(dt) * vel[a], 17);
                    m[a] = d[119] ? p[a] + dd : p[a] - dd;
                end
                for (int a = 0; a < 3; a++) vel[a] = lookup(a[1:0], m);
                for (int a = 0; a < 3; a++) begin
                    dd = rnd_shift(longint'(dt) * vel[a], 16);
                    nv = d[119] ? p[a] + dd : p[a] - dd;
                    if (nv > P_MAX) nv = P_MAX;
                    if (nv < P_MIN) nv = P_MIN;
                    if (a == 0) r.new_x = nv[23:0];
                    else if (a == 1) r.new_y = nv[23:0];
                    else r.new_z = nv[23:0];
                end
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            t_trace_out got, want;
            got = d;
            if (pending.size() == 0) begin
                report_bad("unexpected item", 0, d);
                return;
            end
            want = pending.pop_front();
            if (got.sample_value !== want.sample_value)
                report_bad("sample_value", want.sample_value, got.sample_value);
            if (got.new_x !== want.new_x) report_bad("new_x", want.new_x, got.new_x);
            if (got.new_y !== want.new_y) report_bad("new_y", want.new_y, got.new_y);
            if (got.new_z !== want.new_z) report_bad("new_z", want.new_z, got.new_z);
        endfunction

        function void report_bad(string what, logic [OUT_W-1:0] w, logic [OUT_W-1:0] g);
            errors++;
            if (errors <= 40) $display("error %s: want %h got %h", what, w, g);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic [USER_W-1:0] i_s_tuser = '0;
    logic i_m_tready = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [DT_W-1:0] i_cfg_wdata = '0;
    logic o_s_tready, o_m_tvalid;
    logic [OUT_W-1:0] o_m_tdata;

    grid_scoreboard sb = new();
    int idle_cycles = 0;
    bit hold_off = 0;
    bit timed_out = 0;

    staggered_grid_rk2_trace #(.GRID_CELLS(NCELL)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_input(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT && !timed_out) begin
                timed_out = 1;
                $display("staggered_grid_rk2_trace: mismatch");
                $finish;
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_off) i_m_tready <= 1'b0;
        else i_m_tready <= ($urandom_range(0, 99) < 65);
    end

    task automatic send_item(logic [1:0] op, logic [1:0] c, logic [IN_W-1:0] d);
        i_s_tuser <= {c, op};
        i_s_tdata <= d;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic gap_maybe(ref int burst);
        if (burst > 0) begin
            burst--;
            return;
        end
        i_s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
        burst = $urandom_range(0, 12);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic set_dt(logic [DT_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.dt = v;
    endtask

    function automatic logic [23:0] rand_pos(bit wide);
        int r;
        if (wide) return 24'($urandom);
        r = $urandom_range(0, 20 * 65536) - 2 * 65536;
        return r[23:0];
    endfunction

    function automatic logic [IN_W-1:0] pack(logic [4:0] ci, logic [4:0] cj,
            logic [4:0] ck, logic [31:0] val, logic [23:0] px, logic [23:0] py,
            logic [23:0] pz, logic fwd);
        return {fwd, pz, py, px, val, ck, cj, ci};
    endfunction

    function automatic logic [IN_W-1:0] rand_item(bit wide);
        logic [31:0] val;
        val = $urandom;
        if (!wide) val = $signed(val) >>> $urandom_range(8, 14);
        return pack(5'($urandom_range(0, wide ? 31 : 16)),
                    5'($urandom_range(0, wide ? 31 : 16)),
                    5'($urandom_range(0, wide ? 31 : 16)), val, rand_pos(wide),
                    rand_pos(wide), rand_pos(wide), 1'($urandom_range(0, 1)));
    endfunction

    initial begin
        int burst;
        logic [1:0] op, c;
        logic [DT_W-1:0] dts[4];
        bit wide;
        dts = '{20'd0, 20'hFFFFF, 20'd65536, 20'd30000};
        burst = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, all ops, open codes
        send_item(OP_WRITE, COMP_U, pack(0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0));
        send_item(OP_WRITE, COMP_V, pack(16, 16, 16, 32'h80000000, 0, 0, 0, 0));
        send_item(OP_WRITE, COMP_W, pack(1, 2, 3, 32'h00012345, 0, 0, 0, 1));
        send_item(OP_WRITE, COMP_NONE, pack(1, 1, 1, 32'h11111111, 0, 0, 0, 0));
        send_item(OP_WRITE, COMP_U, pack(17, 0, 0, 32'h22222222, 0, 0, 0, 0));
        send_item(OP_WRITE, COMP_U, pack(31, 31, 31, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  24'hFFFFFF, 1));
        send_item(OP_WRITE, COMP_U, pack(1, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 0));
        send_item(OP_INTERP, COMP_U, pack(0, 0, 0, 0, 24'h008000, 0, 0, 0));
        send_item(OP_INTERP, COMP_U, pack(0, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000, 0));
        send_item(OP_INTERP, COMP_V, pack(0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
        send_item(OP_INTERP, COMP_W, pack(0, 0, 0, 0, 24'h018000, 24'h028000, 24'h030000, 0));
        send_item(OP_INTERP, COMP_NONE, pack(0, 0, 0, 0, 24'h010000, 0, 0, 0));
        send_item(OP_TRACE, COMP_U, pack(0, 0, 0, 0, 24'h008000, 24'h008000, 24'h008000, 1));
        send_item(OP_TRACE, COMP_NONE, pack(0, 0, 0, 0, 24'h7FFFFF, 24'h7FFFFF,
                  24'h7FFFFF, 0));
        send_item(OP_TRACE, COMP_V, pack(0, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000, 1));
        send_item(2'd3, COMP_U, pack(5, 5, 5, 32'h5A5A5A5A, 24'h123456, 0, 0, 1));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            set_dt(dts[ph]);
            for (int n = 0; n < 165; n++) begin
                wide = ($urandom_range(0, 9) == 0);
                op = $urandom_range(0, 9) < 5 ? OP_WRITE : ($urandom_range(0, 1) ? OP_INTERP
                     : OP_TRACE);
                if ($urandom_range(0, 19) == 0) op = 2'd3;
                c = $urandom_range(0, 19) == 0 ? COMP_NONE : 2'($urandom_range(0, 2));
                send_item(op, c, rand_item(wide));
                if (ph == 1 && n == 40) begin
                    hold_off = 1;
                    fork
                        begin
                            repeat (3000) @(negedge i_clk);
                            hold_off = 0;
                        end
                    join_none
                end
                if (ph == 2 && n == 80) begin
                    i_s_tvalid <= 1'b0;
                    while (sb.pending.size() != 0) @(negedge i_clk);
                end
                if (ph != 1 || n < 40 || n > 60) gap_maybe(burst);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("staggered_grid_rk2_trace: match");
        end else begin
            $display("staggered_grid_rk2_trace: mismatch");
        end
        $finish;
    end
endmodule
